[sv/sqlx_pkg.sv]
// Shared types, constants and keyword table of the SQL query lexer.
package sqlx_pkg;

	// Query length limit and derived counter width
	localparam int MAX_QUERY_LEN = 4096;
	localparam int POS_W = $clog2(MAX_QUERY_LEN + 1);

	// Fixed result field widths
	localparam int OFF_W = 12;
	localparam int LEN_W = 13;
	localparam logic [OFF_W-1:0] OFF_MAX = '1;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam int KW_PREFIX = 6;

	// Item queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	// Result queue inside the back part
	localparam int RES_DEPTH = 4;
	localparam int RES_AW = $clog2(RES_DEPTH);

	// Token kinds
	typedef enum logic [2:0] {
		TK_KEYWORD = 3'd0,
		TK_IDENT   = 3'd1,
		TK_INT     = 3'd2,
		TK_STRING  = 3'd3,
		TK_OP      = 3'd4,
		TK_SYMBOL  = 3'd5,
		TK_UNKNOWN = 3'd6,
		TK_END     = 3'd7
	} kind_t;

	// Classified input item
	typedef struct packed {
		logic       func;
		logic [7:0] ch;
		logic [7:0] upper;
		logic       is_space;
		logic       is_id_start;
		logic       is_digit;
		logic       is_quote;
		logic       is_op;
		logic       is_sym;
	} entry_t;

	// Front to back handshake group
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} itm_t;

	// One result item
	typedef struct packed {
		kind_t            kind;
		logic [OFF_W-1:0] start;
		logic [LEN_W-1:0] len;
		logic [2:0]       kw;
		logic [7:0]       ch;
		logic             ovf;
		logic             last;
	} res_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] idx;
	} kw_hit_t;

	// Upper-case keyword text, latest byte lowest
	function automatic logic [47:0] kw_word(input logic [2:0] i);
		case (i)
			3'd0: return 48'h435245415445; // CREATE
			3'd1: return 48'h5441424C45;   // TABLE
			3'd2: return 48'h494E53455254; // INSERT
			3'd3: return 48'h494E544F;     // INTO
			3'd4: return 48'h56414C554553; // VALUES
			3'd5: return 48'h53454C454354; // SELECT
			3'd6: return 48'h46524F4D;     // FROM
			default: return 48'h5748455245; // WHERE
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] kw_len(input logic [2:0] i);
		case (i)
			3'd0, 3'd2, 3'd4, 3'd5: return LEN_W'(6);
			3'd1, 3'd7: return LEN_W'(5);
			default: return LEN_W'(4);
		endcase
	endfunction

	// Compare folded prefix against all eight keywords in parallel
	function automatic kw_hit_t kw_match(input logic [47:0] fold, input logic [LEN_W-1:0] len);
		kw_hit_t r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (len == kw_len(3'(i)) && fold == kw_word(3'(i))) begin
				r.hit = 1'b1;
				r.idx = 3'(i);
			end
		end
		return r;
	endfunction

	// Clamp a position to the offset field
	function automatic logic [OFF_W-1:0] sat_off(input logic [POS_W-1:0] v);
		if (32'(v) > 32'(OFF_MAX))
			return OFF_MAX;
		else
			return OFF_W'(v);
	endfunction

endpackage

[sv/sqlx_front.sv]
// Front part: accepts query items, classifies each byte and queues it for the back part.
module sqlx_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                func,
	input  logic [7:0]          byte_in,
	output sqlx_pkg::itm_t      itm,
	input  logic                take
);
	import sqlx_pkg::*;

	entry_t            q_mem [Q_DEPTH];
	logic [Q_AW-1:0]   wp_q;
	logic [Q_AW-1:0]   rp_q;
	logic [Q_AW:0]     cnt_q;
	logic              acc;
	logic              deq;
	entry_t            cls;

	// Byte classification, C locale
	always_comb begin
		cls = '0;
		cls.func = func;
		cls.ch = byte_in;
		cls.upper = (byte_in >= 8'h61 && byte_in <= 8'h7A) ? byte_in - 8'd32 : byte_in;
		cls.is_space = (byte_in == 8'h20) || (byte_in >= 8'd9 && byte_in <= 8'd13);
		cls.is_id_start = (byte_in >= 8'h41 && byte_in <= 8'h5A) ||
			(byte_in >= 8'h61 && byte_in <= 8'h7A) || (byte_in == 8'h5F);
		cls.is_digit = (byte_in >= 8'h30 && byte_in <= 8'h39);
		cls.is_quote = (byte_in == 8'h22) || (byte_in == 8'h27);
		cls.is_op = (byte_in == 8'h3D) || (byte_in == 8'h3C) || (byte_in == 8'h3E);
		cls.is_sym = (byte_in == 8'h28) || (byte_in == 8'h29) ||
			(byte_in == 8'h2C) || (byte_in == 8'h3B);
	end

	assign full = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign acc = push && !full;
	assign deq = take && (cnt_q != '0);

	assign itm.valid = (cnt_q != '0);
	assign itm.entry = q_mem[rp_q];

	// Item queue storage
	always_ff @(posedge clk) begin
		if (acc)
			q_mem[wp_q] <= cls;
	end

	// Item queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (acc)
				wp_q <= wp_q + Q_AW'(1);
			if (deq)
				rp_q <= rp_q + Q_AW'(1);
			cnt_q <= cnt_q + (Q_AW+1)'(acc) - (Q_AW+1)'(deq);
		end
	end

endmodule

[sv/sqlx_back.sv]
// Back part: token state machine over classified items, plus the result queue.
module sqlx_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sqlx_pkg::itm_t      itm,
	output logic                take,
	output logic                empty,
	input  logic                pop,
	output sqlx_pkg::res_t      head
);
	import sqlx_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE  = 4'b0001,
		M_IDENT = 4'b0010,
		M_NUM   = 4'b0100,
		M_STR   = 4'b1000
	} mode_t;

	// Lexer state
	mode_t              mode_q, mode_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [OFF_W-1:0]   start_q, start_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [47:0]        fold_q, fold_d;
	logic               ovf_q, ovf_d;

	// Result queue
	res_t               r_mem [RES_DEPTH];
	logic [RES_AW-1:0]  rwp_q;
	logic [RES_AW-1:0]  rrp_q;
	logic [RES_AW:0]    rcnt_q;
	logic [RES_AW-1:0]  rwp1;
	logic               out_pop;

	entry_t             ent;
	kw_hit_t            kw;
	res_t               flush_r, idle_r, end_r, r0, r1;
	logic               idle_has;
	logic               go_idle;
	logic [1:0]         n;
	logic               ident;

	assign ent = itm.entry;
	assign take = itm.valid && (rcnt_q <= (RES_AW+1)'(RES_DEPTH - 2));
	assign ident = (mode_q == M_IDENT);

	// Candidate results
	always_comb begin
		kw = kw_match(fold_q, len_q);
		flush_r = '0;
		flush_r.kind = ident ? (kw.hit ? TK_KEYWORD : TK_IDENT) :
			((mode_q == M_NUM) ? TK_INT : TK_STRING);
		flush_r.start = start_q;
		flush_r.len = len_q;
		flush_r.kw = (ident && kw.hit) ? kw.idx : 3'd0;
		flush_r.ovf = ovf_q;

		idle_r = '0;
		idle_r.kind = ent.is_op ? TK_OP : (ent.is_sym ? TK_SYMBOL : TK_UNKNOWN);
		idle_r.start = sat_off(pos_q);
		idle_r.len = LEN_W'(1);
		idle_r.ch = ent.ch;
		idle_r.ovf = ovf_q;
		idle_has = !(ent.is_space || ent.is_id_start || ent.is_digit || ent.is_quote);

		end_r = '0;
		end_r.kind = TK_END;
		end_r.start = sat_off(pos_q);
		end_r.ovf = ovf_q;
	end

	// Next state and emitted results for one item
	always_comb begin
		mode_d = mode_q;
		pos_d = pos_q;
		start_d = start_q;
		len_d = len_q;
		fold_d = fold_q;
		ovf_d = ovf_q;
		r0 = end_r;
		r1 = end_r;
		n = 2'd0;
		go_idle = 1'b0;
		if (take) begin
			if (ent.func) begin
				// end marker: flush open token, then end token, then reset
				if (mode_q != M_IDLE) begin
					r0 = flush_r;
					n = 2'd2;
				end else begin
					n = 2'd1;
				end
				mode_d = M_IDLE;
				pos_d = '0;
				start_d = '0;
				len_d = '0;
				fold_d = '0;
				ovf_d = 1'b0;
			end else if (32'(pos_q) >= MAX_QUERY_LEN) begin
				ovf_d = 1'b1;
			end else begin
				pos_d = pos_q + POS_W'(1);
				case (mode_q)
					M_IDENT: begin
						if (ent.is_id_start || ent.is_digit) begin
							if (len_q < LEN_W'(KW_PREFIX))
								fold_d = {fold_q[39:0], ent.upper};
							if (len_q != LEN_MAX)
								len_d = len_q + LEN_W'(1);
						end else begin
							r0 = flush_r;
							n = 2'd1;
							go_idle = 1'b1;
						end
					end
					M_NUM: begin
						if (ent.is_digit) begin
							if (len_q != LEN_MAX)
								len_d = len_q + LEN_W'(1);
						end else begin
							r0 = flush_r;
							n = 2'd1;
							go_idle = 1'b1;
						end
					end
					M_STR: begin
						if (ent.is_quote) begin
							r0 = flush_r;
							n = 2'd1;
							mode_d = M_IDLE;
						end else if (len_q != LEN_MAX) begin
							len_d = len_q + LEN_W'(1);
						end
					end
					default: go_idle = 1'b1;
				endcase
				// byte lexed from idle: open a token, emit a single-char one, or skip whitespace
				if (go_idle) begin
					mode_d = M_IDLE;
					if (ent.is_id_start) begin
						mode_d = M_IDENT;
						start_d = sat_off(pos_q);
						len_d = LEN_W'(1);
						fold_d = {40'd0, ent.upper};
					end else if (ent.is_digit) begin
						mode_d = M_NUM;
						start_d = sat_off(pos_q);
						len_d = LEN_W'(1);
					end else if (ent.is_quote) begin
						mode_d = M_STR;
						start_d = sat_off(pos_q + POS_W'(1));
						len_d = '0;
					end else if (idle_has) begin
						if (n == 2'd0)
							r0 = idle_r;
						else
							r1 = idle_r;
						n = n + 2'd1;
					end
				end
			end
		end
		r0.last = (n == 2'd1);
		r1.last = (n == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q <= '0;
			start_q <= '0;
			len_q <= '0;
			fold_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			pos_q <= pos_d;
			start_q <= start_d;
			len_q <= len_d;
			fold_q <= fold_d;
			ovf_q <= ovf_d;
		end
	end

	// Result queue: up to two writes, one read per cycle
	assign rwp1 = rwp_q + RES_AW'(1);
	assign empty = (rcnt_q == '0);
	assign out_pop = pop && !empty;
	assign head = r_mem[rrp_q];

	always_ff @(posedge clk) begin
		if (n != 2'd0)
			r_mem[rwp_q] <= r0;
		if (n == 2'd2)
			r_mem[rwp1] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwp_q <= '0;
			rrp_q <= '0;
			rcnt_q <= '0;
		end else begin
			rwp_q <= rwp_q + RES_AW'(n);
			if (out_pop)
				rrp_q <= rrp_q + RES_AW'(1);
			rcnt_q <= rcnt_q + (RES_AW+1)'(n) - (RES_AW+1)'(out_pop);
		end
	end

endmodule

[sv/sql_query_lexer.sv]
// Top level of the SQL query lexer: front classifier, item queue, token engine.
//
//  channel   handshake             payload
//  input     push / full           func, byte_in
//  result    pop / empty           token_kind, start_offset, token_length,
//                                  keyword_index, single_char, overflow, last_of_run
//
// One item per cycle is accepted while the 4-entry item queue has room.
// The token engine takes one item per cycle while the 4-entry result queue has
// two free slots; unpopped results stall it, and then the item queue fills.
// Each accepted item is registered in the item queue, and its results are registered
// in the result queue before they appear on the result ports.
// Reset clears the lexer state and both queues; no clearing pass.
module sql_query_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [7:0]  byte_in,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  token_kind,
	output logic [11:0] start_offset,
	output logic [12:0] token_length,
	output logic [2:0]  keyword_index,
	output logic [7:0]  single_char,
	output logic        overflow,
	output logic        last_of_run
);
	import sqlx_pkg::*;

	itm_t itm;
	logic take;
	res_t head;

	sqlx_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.func    (func),
		.byte_in (byte_in),
		.itm     (itm),
		.take    (take)
	);

	sqlx_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.itm    (itm),
		.take   (take),
		.empty  (empty),
		.pop    (pop),
		.head   (head)
	);

	assign token_kind = head.kind;
	assign start_offset = head.start;
	assign token_length = head.len;
	assign keyword_index = head.kw;
	assign single_char = head.ch;
	assign overflow = head.ovf;
	assign last_of_run = head.last;

`ifndef ASSERT_OFF
	// engine only takes an item the queue holds
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> itm.valid)
		else $error("engine took an item from an empty queue");

	// the end token always closes its run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token_kind == TK_END) |-> last_of_run)
		else $error("end token without last_of_run");

	// only single-char tokens carry a character
	a_char_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && single_char != 8'd0) |->
		(token_kind == TK_OP || token_kind == TK_SYMBOL || token_kind == TK_UNKNOWN))
		else $error("character on a multi-byte token");

	// keyword index is zero unless the token is a keyword
	a_kw_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token_kind != TK_KEYWORD) |-> keyword_index == 3'd0)
		else $error("keyword index on a non-keyword token");
`endif

endmodule
